/* rtl/sist_pkg.sv */
package sist_pkg;

  localparam int DEFAULT_CAPACITY = 16;
  localparam int DATA_W = 32;
  localparam int OUT_IDX_W = 5;

  localparam logic [1:0] ACT_INSERT = 2'd0;
  localparam logic [1:0] ACT_DELETE = 2'd1;
  localparam logic [1:0] ACT_QUERY  = 2'd2;

  localparam logic [1:0] STS_OK     = 2'd0;
  localparam logic [1:0] STS_FULL   = 2'd1;
  localparam logic [1:0] STS_ABSENT = 2'd2;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_LOOK,
    ST_MOVE
  } state_t;

  // per-cycle command broadcast to every cell
  typedef struct packed {
    logic ins_en;
    logic del_en;
  } cell_ctl_t;

endpackage

/* rtl/sist_cell.sv */
module sist_cell (
  input  logic                      clk,
  input  logic                      rst,
  input  sist_pkg::cell_ctl_t       ctl,
  input  logic                      occ_prev,
  input  logic                      occ_nxt,
  input  logic [sist_pkg::DATA_W-1:0] key,
  input  logic                      move_en,
  input  logic [sist_pkg::DATA_W-1:0] move_data,
  output logic                      occ,
  output logic [sist_pkg::DATA_W-1:0] entry,
  output logic                      match,
  output logic                      last
);
  import sist_pkg::*;

  // occupancy is a thermometer: inserts shift it up, deletes shift it down
  always_ff @(posedge clk) begin
    if (rst) begin
      occ <= 1'b0;
    end else if (ctl.ins_en) begin
      occ <= occ_prev;
    end else if (ctl.del_en) begin
      occ <= occ_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.ins_en && !occ && occ_prev) begin
      entry <= key;
    end else if (move_en) begin
      entry <= move_data;
    end
  end

  assign match = occ && (entry == key);
  assign last  = occ && !occ_nxt;

endmodule

/* rtl/sist_reduce.sv */
module sist_reduce #(
  parameter int CAPACITY = sist_pkg::DEFAULT_CAPACITY,
  parameter int IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1
) (
  input  logic [CAPACITY-1:0]         match,
  input  logic [CAPACITY-1:0]         last,
  input  logic [sist_pkg::DATA_W-1:0] entries [CAPACITY],
  output logic                        hit,
  output logic [IW-1:0]               hit_idx,
  output logic [sist_pkg::DATA_W-1:0] last_val
);
  import sist_pkg::*;

  // values are distinct, so at most one cell matches and an OR picks its index
  always_comb begin
    hit_idx  = '0;
    last_val = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      hit_idx  = hit_idx | (match[i] ? IW'(i) : '0);
      last_val = last_val | (last[i] ? entries[i] : '0);
    end
  end

  assign hit = |match;

endmodule

/* rtl/small_integer_set_table.sv */
// Result: the request is captured, compared across all cells in ST_LOOK, and
//   registered when the output register is free (out_valid low or out_ready high).
// Requests: in_ready is low in ST_LOOK, so a new one waits for the lookup; a delete
//   then moves the last entry into the freed cell (ST_MOVE) while the next is taken.
// Output register lets a new request be taken while a result waits.
// Reset (synchronous, rst high) empties the set; entry data is not cleared.
module small_integer_set_table #(
  parameter int CAPACITY = sist_pkg::DEFAULT_CAPACITY
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [1:0]                  action,
  input  logic signed [sist_pkg::DATA_W-1:0] value,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic                        found,
  output logic [sist_pkg::OUT_IDX_W-1:0] position,
  output logic [sist_pkg::OUT_IDX_W-1:0] count_after,
  output logic [1:0]                  status
);
  import sist_pkg::*;

  localparam int IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CW = $clog2(CAPACITY + 1);
  localparam int WIDE_W = 9;

  state_t state, state_next;

  logic [1:0]        req_action;
  logic [DATA_W-1:0] req_value;
  logic [CW-1:0]     count;
  logic [CW-1:0]     count_next;
  logic [IW-1:0]     move_pos;
  logic [DATA_W-1:0] move_val;

  logic              accept, out_free, look_fire;
  logic              is_ins, is_del, full;
  cell_ctl_t         ctl;

  logic [CAPACITY-1:0] occ, match, last;
  logic [DATA_W-1:0]   entries [CAPACITY];
  logic                hit;
  logic [IW-1:0]       hit_idx;
  logic [DATA_W-1:0]   last_val;

  logic [CW-1:0]     pos_full;
  logic [WIDE_W-1:0] pos_wide, cnt_wide;
  logic [1:0]        sts;

  assign in_ready  = (state != ST_LOOK);
  assign accept    = in_valid && in_ready;
  assign out_free  = !out_valid || out_ready;
  assign look_fire = (state == ST_LOOK) && out_free;

  assign is_ins = (req_action == ACT_INSERT);
  assign is_del = (req_action == ACT_DELETE);
  assign full   = (count == CW'(CAPACITY));

  assign ctl.ins_en = look_fire && is_ins && !hit && !full;
  assign ctl.del_en = look_fire && is_del && hit;

  genvar g;
  generate
    for (g = 0; g < CAPACITY; g++) begin : g_cell
      logic occ_prev_g, occ_nxt_g;
      if (g == 0) begin : g_first
        assign occ_prev_g = 1'b1;
      end else begin : g_mid_prev
        assign occ_prev_g = occ[g-1];
      end
      if (g == CAPACITY - 1) begin : g_last
        assign occ_nxt_g = 1'b0;
      end else begin : g_mid_nxt
        assign occ_nxt_g = occ[g+1];
      end

      sist_cell u_cell (
        .clk       (clk),
        .rst       (rst),
        .ctl       (ctl),
        .occ_prev  (occ_prev_g),
        .occ_nxt   (occ_nxt_g),
        .key       (req_value),
        .move_en   ((state == ST_MOVE) && (move_pos == IW'(g))),
        .move_data (move_val),
        .occ       (occ[g]),
        .entry     (entries[g]),
        .match     (match[g]),
        .last      (last[g])
      );
    end
  endgenerate

  sist_reduce #(
    .CAPACITY (CAPACITY),
    .IW       (IW)
  ) u_reduce (
    .match    (match),
    .last     (last),
    .entries  (entries),
    .hit      (hit),
    .hit_idx  (hit_idx),
    .last_val (last_val)
  );

  always_comb begin
    count_next = count;
    if (ctl.ins_en) begin
      count_next = count + CW'(1);
    end else if (ctl.del_en) begin
      count_next = count - CW'(1);
    end
  end

  always_comb begin
    sts = STS_OK;
    if (is_ins && !hit && full) begin
      sts = STS_FULL;
    end else if (is_del && !hit) begin
      sts = STS_ABSENT;
    end
  end

  assign pos_full = hit ? CW'(hit_idx) : count;
  assign pos_wide = WIDE_W'(pos_full);
  assign cnt_wide = WIDE_W'(count_next);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (accept) state_next = ST_LOOK;
      end
      ST_LOOK: begin
        if (look_fire) state_next = ctl.del_en ? ST_MOVE : ST_IDLE;
      end
      ST_MOVE: begin
        state_next = accept ? ST_LOOK : ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      out_valid <= 1'b0;
    end else begin
      count <= count_next;
      if (look_fire) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      req_action <= action;
      req_value  <= value;
    end
    if (ctl.del_en) begin
      move_pos <= hit_idx;
      move_val <= last_val;
    end
    if (look_fire) begin
      found       <= hit;
      position    <= pos_wide[OUT_IDX_W-1:0];
      count_after <= cnt_wide[OUT_IDX_W-1:0];
      status      <= sts;
    end
  end

endmodule

/* rtl/sist_checker.sv */
module sist_checker (
  input logic                        clk,
  input logic                        rst,
  input logic                        in_valid,
  input logic                        in_ready,
  input logic [1:0]                  action,
  input logic [sist_pkg::DATA_W-1:0] value,
  input logic                        out_valid,
  input logic                        out_ready,
  input logic                        found,
  input logic [sist_pkg::OUT_IDX_W-1:0] position,
  input logic [sist_pkg::OUT_IDX_W-1:0] count_after,
  input logic [1:0]                  status
);
  import sist_pkg::*;

  logic out_xfer;
  assign out_xfer = out_valid && out_ready;

  a_reset_clears: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result pending after reset");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(found) && $stable(position)
      && $stable(count_after) && $stable(status))
    else $error("stalled result changed");

  a_refused_absent: assert property (@(posedge clk) disable iff (rst)
    out_xfer && (status == STS_FULL || status == STS_ABSENT)
      |-> !found && position == count_after)
    else $error("refused request reports a hit or a count change");

  a_absent_pos: assert property (@(posedge clk) disable iff (rst)
    out_xfer && status == STS_OK && !found
      |-> position == count_after || OUT_IDX_W'(position + 1'b1) == count_after)
    else $error("absent value position is not the count");

  a_found_ok: assert property (@(posedge clk) disable iff (rst)
    out_xfer && found |-> status == STS_OK)
    else $error("hit reported with error status");

endmodule

bind small_integer_set_table sist_checker u_sist_checker (.*);

/* verif/tb_small_integer_set_table.sv */
module tb_small_integer_set_table;
  import sist_pkg::*;

  localparam int CAPACITY = DEFAULT_CAPACITY;
  localparam int STALL_LIMIT = 2000;
  localparam int RANDOM_ITEMS = 1200;
  localparam int POOL_SIZE = 20;
  localparam logic [1:0] ACT_SPARE = 2'd3;  // undefined code, behaves as a query

  typedef struct {
    logic [1:0]  action;
    logic [31:0] value;
    bit          hold_till_drained;
  } set_request_t;

  typedef struct {
    logic                 found;
    logic [OUT_IDX_W-1:0] position;
    logic [OUT_IDX_W-1:0] count_after;
    logic [1:0]           status;
  } set_result_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [1:0] action = ACT_QUERY;
  logic signed [DATA_W-1:0] value = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic found;
  logic [OUT_IDX_W-1:0] position;
  logic [OUT_IDX_W-1:0] count_after;
  logic [1:0] status;

  set_request_t pending_requests[$];
  set_result_t  expected_results[$];
  set_request_t active_request;

  // shadow copy of the set
  logic [31:0] shadow_slots[CAPACITY];
  int          shadow_count = 0;

  int total_requests = 0;
  int accepted_requests = 0;
  int error_count = 0;
  int stall_cycles = 0;

  small_integer_set_table #(.CAPACITY(CAPACITY)) dut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .action(action),
    .value(value),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .found(found),
    .position(position),
    .count_after(count_after),
    .status(status)
  );

  always #6 clk = ~clk;

  function automatic set_result_t apply_to_shadow(set_request_t req);
    set_result_t res;
    int slot;
    slot = shadow_count;
    for (int i = shadow_count - 1; i >= 0; i--) begin
      if (shadow_slots[i] == req.value) slot = i;
    end
    res.found = (slot < shadow_count);
    res.status = STS_OK;
    if (req.action == ACT_INSERT) begin
      if (!res.found) begin
        if (shadow_count < CAPACITY) begin
          shadow_slots[shadow_count] = req.value;
          shadow_count++;
        end else begin
          res.status = STS_FULL;
        end
      end
    end else if (req.action == ACT_DELETE) begin
      if (res.found) begin
        shadow_slots[slot] = shadow_slots[shadow_count - 1];
        shadow_count--;
      end else begin
        res.status = STS_ABSENT;
      end
    end
    res.position = slot[OUT_IDX_W-1:0];
    res.count_after = shadow_count[OUT_IDX_W-1:0];
    return res;
  endfunction

  task automatic report(string msg);
    $display("ERROR @%0t: %s", $time, msg);
    error_count++;
  endtask

  task automatic queue_request(logic [1:0] act, logic [31:0] val, bit hold = 0);
    set_request_t req;
    req.action = act;
    req.value = val;
    req.hold_till_drained = hold;
    pending_requests.push_back(req);
  endtask

  // idle percentages: sender light / receiver heavy, then swapped, then none
  function automatic int idle_pct(bit sender);
    int phase;
    phase = (accepted_requests * 3) / (total_requests == 0 ? 1 : total_requests);
    if (phase == 0) return sender ? 8 : 60;
    if (phase == 1) return sender ? 60 : 8;
    return 0;
  endfunction

  // driver
  always @(posedge clk) begin
    set_request_t next_req;
    logic present;
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      present = 1'b0;
      if (in_valid && in_ready) begin
        expected_results.push_back(apply_to_shadow(active_request));
        accepted_requests <= accepted_requests + 1;
      end
      if (!in_valid || in_ready) begin
        if (pending_requests.size() != 0 && $urandom_range(99) >= idle_pct(1'b1) &&
            !(pending_requests[0].hold_till_drained && expected_results.size() != 0)) begin
          next_req = pending_requests.pop_front();
          present = 1'b1;
          active_request <= next_req;
          action <= next_req.action;
          value <= next_req.value;
        end
        in_valid <= present;
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    set_result_t want;
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (expected_results.size() == 0) begin
          report("result transaction with no request outstanding");
        end else begin
          want = expected_results.pop_front();
          if (found !== want.found)
            report($sformatf("found: expected %0d, got %0d", want.found, found));
          if (position !== want.position)
            report($sformatf("position: expected %0d, got %0d", want.position, position));
          if (count_after !== want.count_after)
            report($sformatf("count_after: expected %0d, got %0d",
                             want.count_after, count_after));
          if (status !== want.status)
            report($sformatf("status: expected %0d, got %0d", want.status, status));
        end
      end
      out_ready <= ($urandom_range(99) >= idle_pct(1'b0));
    end
  end

  // watchdog
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("tb: failure");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  initial begin
    logic [31:0] value_pool[POOL_SIZE];
    logic [1:0] act;
    logic [31:0] val;
    bit filling;
    int mode_left;
    int roll;

    // directed: empty set, extremes, duplicates, swap-on-delete, full table
    queue_request(ACT_QUERY, 32'h0000_0000);
    queue_request(ACT_DELETE, 32'h0000_0000);
    queue_request(ACT_INSERT, 32'h0000_0000);
    queue_request(ACT_INSERT, 32'hffff_ffff);
    queue_request(ACT_INSERT, 32'h8000_0000);
    queue_request(ACT_INSERT, 32'h7fff_ffff);
    queue_request(ACT_INSERT, 32'hffff_ffff);
    queue_request(ACT_QUERY, 32'h7fff_ffff);
    queue_request(ACT_SPARE, 32'h8000_0000);
    queue_request(ACT_DELETE, 32'h0000_0000);
    queue_request(ACT_QUERY, 32'h7fff_ffff);
    for (int i = 0; i < 13; i++)
      queue_request(ACT_INSERT, ((i % 2) ? 32'haaaa_aaaa : 32'h5555_5555) ^ i);
    queue_request(ACT_INSERT, 32'h0000_0005);
    queue_request(ACT_INSERT, 32'h8000_0000);

    filling = 1'b0;
    mode_left = 0;
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n % 150 == 0) begin
        value_pool[0] = 32'h0000_0000;
        value_pool[1] = 32'hffff_ffff;
        value_pool[2] = 32'h8000_0000;
        value_pool[3] = 32'h7fff_ffff;
        for (int k = 4; k < POOL_SIZE; k++) value_pool[k] = $urandom;
      end
      // alternate fill-heavy and drain-heavy stretches so full and empty both occur
      if (mode_left == 0) begin
        filling = !filling;
        mode_left = $urandom_range(60, 20);
      end
      mode_left--;
      roll = $urandom_range(99);
      if (roll < 5) act = ACT_SPARE;
      else if (roll < 25) act = ACT_QUERY;
      else if (roll < 80) act = filling ? ACT_INSERT : ACT_DELETE;
      else act = filling ? ACT_DELETE : ACT_INSERT;
      val = ($urandom_range(9) == 0) ? $urandom : value_pool[$urandom_range(POOL_SIZE - 1)];
      queue_request(act, val, (n == 0) || (n == RANDOM_ITEMS / 2));
    end
    total_requests = pending_requests.size();

    repeat (6) @(posedge clk);
    rst <= 1'b0;

    while (accepted_requests != total_requests) @(posedge clk);
    while (expected_results.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (error_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
